@@ src/vic_pkg.sv @@
`default_nettype none

package vic_pkg;

	// Maximum byte counts for each operand width
	localparam logic [3:0] MAX_BYTES_W8  = 4'd2;
	localparam logic [3:0] MAX_BYTES_W16 = 4'd3;
	localparam logic [3:0] MAX_BYTES_W32 = 4'd5;
	localparam logic [3:0] MAX_BYTES_W64 = 4'd10;

	// Group layout of one encoded byte
	localparam logic [7:0] GROUP_MASK = 8'h7f;
	localparam logic [7:0] CONT_BIT   = 8'h80;

	// An encode shifts out at most this many continuation groups
	localparam logic [3:0] ENC_CONT_MAX = 4'd9;

	// Operand width codes
	localparam logic [1:0] VW_8  = 2'd0;
	localparam logic [1:0] VW_16 = 2'd1;
	localparam logic [1:0] VW_32 = 2'd2;
	localparam logic [1:0] VW_64 = 2'd3;
	localparam logic [1:0] VW_RESET = VW_64;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_VALUE   = 2'd1,
		KIND_REFUSED = 2'd2,
		KIND_FAILED  = 2'd3
	} kind_t;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_NONE        = 3'd0,
		OP_LOAD        = 3'd1,
		OP_EMIT_ENC    = 3'd2,
		OP_EMIT_REFUSE = 3'd3,
		OP_MERGE       = 3'd4,
		OP_EMIT_VAL    = 3'd5,
		OP_EMIT_FAIL   = 3'd6
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		COND_ALWAYS   = 3'd0,
		COND_DECODE   = 3'd1,
		COND_ROOM_LOW = 3'd2,
		COND_MORE     = 3'd3,
		COND_DONE     = 3'd4,
		COND_FAIL     = 3'd5
	} cond_t;

	// Microprogram addresses
	typedef logic [2:0] step_t;

	localparam step_t ST_FETCH    = 3'd0;
	localparam step_t ST_ENC_CHK  = 3'd1;
	localparam step_t ST_ENC_EMIT = 3'd2;
	localparam step_t ST_REFUSE   = 3'd3;
	localparam step_t ST_MERGE    = 3'd4;
	localparam step_t ST_DEC_VAL  = 3'd5;
	localparam step_t ST_DEC_FAIL = 3'd6;
	localparam step_t ST_DEC_CHK  = 3'd7;

	// One control word
	typedef struct packed {
		logic  wait_in;
		logic  emit;
		op_t   op;
		cond_t cond;
		step_t jump;
		step_t seq;
	} cw_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic decode;
		logic room_low;
		logic more;
		logic done;
		logic fail;
	} status_t;

	// One result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [63:0] out_value;
		logic        last;
	} result_t;

	function automatic logic [63:0] width_mask(input logic [1:0] vw);
		logic [63:0] m;
		unique case (vw)
			VW_8:    m = 64'h0000_0000_0000_00ff;
			VW_16:   m = 64'h0000_0000_0000_ffff;
			VW_32:   m = 64'h0000_0000_ffff_ffff;
			default: m = 64'hffff_ffff_ffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] max_bytes(input logic [1:0] vw);
		logic [3:0] n;
		unique case (vw)
			VW_8:    n = MAX_BYTES_W8;
			VW_16:   n = MAX_BYTES_W16;
			VW_32:   n = MAX_BYTES_W32;
			default: n = MAX_BYTES_W64;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ src/vic_if.sv @@
`default_nettype none

// Request channel: one encode or decode item
interface vic_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [63:0] value;
	logic [7:0]  in_byte;
	logic [7:0]  space_left;
	logic        end_of_buffer;

	modport source (output valid, action, value, in_byte, space_left, end_of_buffer,
		input ready);
	modport sink (input valid, action, value, in_byte, space_left, end_of_buffer,
		output ready);
endinterface

// Response channel: one result item
interface vic_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  out_byte;
	logic [63:0] out_value;
	logic        last;

	modport source (output valid, kind, out_byte, out_value, last, input ready);
	modport sink (input valid, kind, out_byte, out_value, last, output ready);
endinterface

// Configuration write channel
interface vic_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] value_width;

	modport source (output valid, value_width, input ready);
	modport sink (input valid, value_width, output ready);
endinterface

`default_nettype wire

@@ src/vic_ucode_rom.sv @@
`default_nettype none

module vic_ucode_rom (
	input  vic_pkg::step_t addr,
	output vic_pkg::cw_t   cw
);

	// Control store: wait_in, emit, op, cond, jump, seq
	always_comb begin
		unique case (addr)
			vic_pkg::ST_FETCH: begin
				cw = '{1'b1, 1'b0, vic_pkg::OP_NONE, vic_pkg::COND_DECODE,
					vic_pkg::ST_MERGE, vic_pkg::ST_ENC_CHK};
			end
			vic_pkg::ST_ENC_CHK: begin
				cw = '{1'b0, 1'b0, vic_pkg::OP_LOAD, vic_pkg::COND_ROOM_LOW,
					vic_pkg::ST_REFUSE, vic_pkg::ST_ENC_EMIT};
			end
			vic_pkg::ST_ENC_EMIT: begin
				cw = '{1'b0, 1'b1, vic_pkg::OP_EMIT_ENC, vic_pkg::COND_MORE,
					vic_pkg::ST_ENC_EMIT, vic_pkg::ST_FETCH};
			end
			vic_pkg::ST_REFUSE: begin
				cw = '{1'b0, 1'b1, vic_pkg::OP_EMIT_REFUSE, vic_pkg::COND_ALWAYS,
					vic_pkg::ST_FETCH, vic_pkg::ST_FETCH};
			end
			vic_pkg::ST_MERGE: begin
				cw = '{1'b0, 1'b0, vic_pkg::OP_MERGE, vic_pkg::COND_DONE,
					vic_pkg::ST_DEC_VAL, vic_pkg::ST_DEC_CHK};
			end
			vic_pkg::ST_DEC_VAL: begin
				cw = '{1'b0, 1'b1, vic_pkg::OP_EMIT_VAL, vic_pkg::COND_ALWAYS,
					vic_pkg::ST_FETCH, vic_pkg::ST_FETCH};
			end
			vic_pkg::ST_DEC_FAIL: begin
				cw = '{1'b0, 1'b1, vic_pkg::OP_EMIT_FAIL, vic_pkg::COND_ALWAYS,
					vic_pkg::ST_FETCH, vic_pkg::ST_FETCH};
			end
			vic_pkg::ST_DEC_CHK: begin
				cw = '{1'b0, 1'b0, vic_pkg::OP_NONE, vic_pkg::COND_FAIL,
					vic_pkg::ST_DEC_FAIL, vic_pkg::ST_FETCH};
			end
			default: begin
				cw = '{1'b1, 1'b0, vic_pkg::OP_NONE, vic_pkg::COND_DECODE,
					vic_pkg::ST_MERGE, vic_pkg::ST_ENC_CHK};
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/vic_datapath.sv @@
`default_nettype none

module vic_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        value_width,
	input  logic              load_in,
	input  logic              in_action,
	input  logic [63:0]       in_value,
	input  logic [7:0]        in_byte,
	input  logic [7:0]        in_space,
	input  logic              in_eob,
	input  logic              fire,
	input  vic_pkg::op_t      op,
	output vic_pkg::status_t  status,
	output vic_pkg::result_t  res
);

	logic [63:0]      val_q;
	logic [7:0]       byte_q;
	logic [7:0]       room_q;
	logic             eob_q;
	logic [3:0]       cnt_q;
	logic [63:0]      acc_q;
	logic [3:0]       bs_q;
	vic_pkg::result_t res_q;

	logic [63:0] mask;
	logic [3:0]  maxb;
	logic        more;
	logic [6:0]  shamt;
	logic [63:0] grp;
	logic [7:0]  enc_byte;

	assign mask = vic_pkg::width_mask(value_width);
	assign maxb = vic_pkg::max_bytes(value_width);

	// Another group follows while the rest exceeds seven bits
	assign more     = (val_q > {56'd0, vic_pkg::GROUP_MASK}) && (cnt_q < vic_pkg::ENC_CONT_MAX);
	assign enc_byte = more ? ((val_q[7:0] & vic_pkg::GROUP_MASK) | vic_pkg::CONT_BIT)
		: val_q[7:0];

	// Place the incoming group at bit 7*bytes_seen; shifts past 63 drop it
	assign shamt = 7'({3'd0, bs_q} * 7'd7);
	assign grp   = {57'd0, byte_q[6:0]} << shamt;

	assign status.decode   = in_action;
	assign status.room_low = room_q < {4'd0, maxb};
	assign status.more     = more;
	assign status.done     = ~byte_q[7];
	assign status.fail     = (bs_q >= maxb) || eob_q;

	assign res = res_q;

	// Capture the item, then run encode steps and load results
	always_ff @(posedge clk) begin
		if (load_in) begin
			val_q  <= in_value;
			byte_q <= in_byte;
			room_q <= in_space;
			eob_q  <= in_eob;
		end else if (fire) begin
			unique case (op)
				vic_pkg::OP_LOAD: begin
					val_q <= val_q & mask;
					cnt_q <= 4'd0;
				end
				vic_pkg::OP_EMIT_ENC: begin
					res_q <= '{vic_pkg::KIND_BYTE, enc_byte, 64'd0, ~more};
					val_q <= val_q >> 7;
					cnt_q <= cnt_q + 4'd1;
				end
				vic_pkg::OP_EMIT_REFUSE: begin
					res_q <= '{vic_pkg::KIND_REFUSED, 8'd0, 64'd0, 1'b1};
				end
				vic_pkg::OP_EMIT_VAL: begin
					res_q <= '{vic_pkg::KIND_VALUE, 8'd0, acc_q, 1'b1};
				end
				vic_pkg::OP_EMIT_FAIL: begin
					res_q <= '{vic_pkg::KIND_FAILED, 8'd0, 64'd0, 1'b1};
				end
				default: begin
				end
			endcase
		end
	end

	// Decode state: merge groups, clear after a value or a failure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 64'd0;
			bs_q  <= 4'd0;
		end else if (fire) begin
			unique case (op)
				vic_pkg::OP_MERGE: begin
					acc_q <= (acc_q | grp) & mask;
					bs_q  <= bs_q + 4'd1;
				end
				vic_pkg::OP_EMIT_VAL, vic_pkg::OP_EMIT_FAIL: begin
					acc_q <= 64'd0;
					bs_q  <= 4'd0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/varint_codec.sv @@
`default_nettype none
// Steps: encode goes fetch, load with a room check, then a byte or a refusal, then one
// byte a cycle while results are read; decode goes fetch, merge, then a value or a check
// that fails or awaits the next byte. The input is held until an item's steps are done,
// and every emit step stalls while the result is unread.
// Reset (arst_n low): width 64 bits, decode state cleared, sequencer at fetch.
module varint_codec (
	input  wire  clk,
	input  wire  arst_n,
	vic_req_if.sink   req,
	vic_rsp_if.source rsp,
	vic_cfg_if.sink   cfg
);

	vic_pkg::step_t   step_q;
	vic_pkg::step_t   step_d;
	vic_pkg::cw_t     cw;
	vic_pkg::status_t st;
	vic_pkg::result_t res;
	logic [1:0]       value_width_q;
	logic             rsp_valid_q;
	logic             req_acc;
	logic             slot_free;
	logic             go;
	logic             cond_ok;

	vic_ucode_rom u_rom (
		.addr (step_q),
		.cw   (cw)
	);

	vic_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_width (value_width_q),
		.load_in     (req_acc),
		.in_action   (req.action),
		.in_value    (req.value),
		.in_byte     (req.in_byte),
		.in_space    (req.space_left),
		.in_eob      (req.end_of_buffer),
		.fire        (go),
		.op          (cw.op),
		.status      (st),
		.res         (res)
	);

	// Handshakes
	assign req.ready = cw.wait_in;
	assign req_acc   = req.valid && cw.wait_in;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign go        = (!cw.wait_in || req_acc) && (!cw.emit || slot_free);
	assign cfg.ready = 1'b1;

	assign rsp.valid     = rsp_valid_q;
	assign rsp.kind      = res.kind;
	assign rsp.out_byte  = res.out_byte;
	assign rsp.out_value = res.out_value;
	assign rsp.last      = res.last;

	// Pick the jump condition
	always_comb begin
		unique case (cw.cond)
			vic_pkg::COND_ALWAYS:   cond_ok = 1'b1;
			vic_pkg::COND_DECODE:   cond_ok = st.decode;
			vic_pkg::COND_ROOM_LOW: cond_ok = st.room_low;
			vic_pkg::COND_MORE:     cond_ok = st.more;
			vic_pkg::COND_DONE:     cond_ok = st.done;
			vic_pkg::COND_FAIL:     cond_ok = st.fail;
			default:                cond_ok = 1'b0;
		endcase
	end

	assign step_d = go ? (cond_ok ? cw.jump : cw.seq) : step_q;

	// Advance the step counter, hold the result slot, take config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= vic_pkg::ST_FETCH;
			rsp_valid_q   <= 1'b0;
			value_width_q <= vic_pkg::VW_RESET;
		end else begin
			step_q <= step_d;
			if (cw.emit && go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				value_width_q <= cfg.value_width;
			end
		end
	end

	// An accepted item always leaves the fetch step
	a_fetch_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> step_q != vic_pkg::ST_FETCH)
		else $error("sequencer stayed at fetch after an item");

	// Only encoded bytes can be non-final results
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind != vic_pkg::KIND_BYTE |-> rsp.last)
		else $error("non-byte result without last");

	// Non-final encoded bytes carry the continuation mark
	a_cont_mark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind == vic_pkg::KIND_BYTE && !rsp.last |-> rsp.out_byte[7])
		else $error("continuation mark missing");

	// Value field is zero outside decoded values
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.kind != vic_pkg::KIND_VALUE |-> rsp.out_value == 64'd0)
		else $error("stray decoded value");

endmodule

`default_nettype wire
